// File: design/mwtm_pkg.sv
package mwtm_pkg;

    localparam int GRID_CELLS_DEF = 4096;
    localparam int VSUM_W = 64;
    localparam int WSUM_W = 40;
    localparam int TOT_W = 48;

    localparam logic [1:0] CMD_CHUNK = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [2:0] REG_IN_MISS = 3'd0;
    localparam logic [2:0] REG_OUT_MISS = 3'd1;
    localparam logic [2:0] REG_LIMIT = 3'd2;
    localparam logic [2:0] REG_INTEG = 3'd3;
    localparam logic [2:0] REG_SCALE = 3'd4;
    localparam logic [2:0] REG_IGNORE = 3'd5;

    localparam logic [31:0] MISS_RESET = 32'hFFFC_1900;
    localparam logic [23:0] ONE_Q8 = 24'd256;

    // controller to datapath
    typedef struct packed {
        logic clr_step;   // write zero at sweep address
        logic take;       // capture input transaction
        logic rd_issue;   // read cell memories
        logic exec;       // apply command with read data
        logic div_start;
        logic out_load;   // load result register from datapath
    } mwtm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic need_div;   // result needs the divider
        logic has_out;    // command produces a result
        logic div_done;
    } mwtm_stat_t;

endpackage

// File: design/mwtm_ram.sv
module mwtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/mwtm_div.sv
// Restoring divider, one quotient bit per cycle: 64 bit dividend by 40 bit divisor.
module mwtm_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [39:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] quo_reg;
    logic [40:0] rem_reg;
    logic [39:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [40:0] trial;
    logic [40:0] diff;

    assign trial = {rem_reg[39:0], quo_reg[63]};
    assign diff = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[40])
            begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

// File: design/mwtm_ctrl.sv
module mwtm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    output mwtm_pkg::mwtm_cmd_t    cmd,
    input  mwtm_pkg::mwtm_stat_t   stat
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   take;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign take = (state_reg == S_IDLE) && in_valid;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.clr_step = (state_reg == S_CLEAR);
        cmd.take = take;
        cmd.rd_issue = (state_reg == S_READ);
        cmd.exec = (state_reg == S_EXEC);
        cmd.div_start = (state_reg == S_EXEC) && stat.has_out && stat.need_div;
        cmd.out_load = (state_reg == S_OUT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    if (stat.clr_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (!stat.has_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (stat.need_div)
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    if (stat.div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !take)
        else $error("input taken while busy");
    a_load_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");
    a_div_path: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == S_DIV))
        else $error("divide not tracked");
`endif

endmodule

// File: design/mwtm_dp.sv
module mwtm_dp #(
    parameter int GRID_CELLS = mwtm_pkg::GRID_CELLS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mwtm_pkg::mwtm_cmd_t   cmd,
    output mwtm_pkg::mwtm_stat_t  stat,
    input  logic                  cfg_valid,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic [1:0]            in_cmd,
    input  logic [11:0]           cell_req,
    input  logic signed [31:0]    sample_value,
    input  logic signed [23:0]    chunk_hours,
    output logic signed [31:0]    mean_value,
    output logic                  is_missing,
    output logic                  status
);

    localparam int AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int RD = (GRID_CELLS > 1) ? GRID_CELLS : 2;
    localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    logic [31:0] in_miss_reg;
    logic [31:0] out_miss_reg;
    logic [16:0] limit_reg;
    logic        integ_reg;
    logic [31:0] scale_reg;
    logic        ignore_reg;

    logic [47:0] tot_w_reg;
    logic [47:0] tot_d_reg;
    logic [23:0] chunk_w_reg;
    logic [15:0] chunk_cnt_reg;

    logic [AW:0] clr_addr_reg;

    logic [1:0]  cmd_reg;
    logic [11:0] cell_reg;
    logic [31:0] sv_reg;
    logic [23:0] ch_reg;

    logic [63:0] vs_rd;
    logic [39:0] ws_rd;
    logic        we;
    logic [AW-1:0] waddr;
    logic [63:0] vs_wd;
    logic [39:0] ws_wd;
    logic        in_range;

    logic [63:0] prod;
    logic [64:0] vs_add;
    logic [63:0] vs_sat;
    logic [40:0] ws_add;

    logic [16:0] lf;
    logic [64:0] lim_prod;
    logic        neg;
    logic [63:0] s_mag;
    logic [63:0] num;
    logic        neg_reg;
    logic        miss_reg;
    logic        integ_res_reg;
    logic        rej_reg;
    logic        chunk_res_reg;
    logic [63:0] hi_p;
    logic [63:0] lo_p;
    logic [63:0] isum;
    logic [63:0] quo;
    logic        div_done;
    logic [32:0] mag;
    logic [31:0] res_val;
    logic [23:0] dt;
    logic        reject;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_miss_reg <= mwtm_pkg::MISS_RESET;
            out_miss_reg <= mwtm_pkg::MISS_RESET;
            limit_reg <= '0;
            integ_reg <= 1'b0;
            scale_reg <= 32'd65536;
            ignore_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mwtm_pkg::REG_IN_MISS: in_miss_reg <= cfg_data;
                mwtm_pkg::REG_OUT_MISS: out_miss_reg <= cfg_data;
                mwtm_pkg::REG_LIMIT: limit_reg <= cfg_data[16:0];
                mwtm_pkg::REG_INTEG: integ_reg <= cfg_data[0];
                mwtm_pkg::REG_SCALE: scale_reg <= cfg_data;
                mwtm_pkg::REG_IGNORE: ignore_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            cmd_reg <= in_cmd;
            cell_reg <= cell_req;
            sv_reg <= sample_value;
            ch_reg <= chunk_hours;
        end
    end

    assign in_range = ({20'd0, cell_reg} < 32'(GRID_CELLS));
    assign dt = ch_reg[23] ? 24'd0 : ch_reg;
    assign reject = (dt == 24'd0) && (tot_d_reg != 48'd0) && !ignore_reg;

    // accumulate
    assign prod = 64'($signed(sv_reg) * $signed({1'b0, chunk_w_reg}));
    assign vs_add = {vs_rd[63], vs_rd} + {prod[63], prod};
    assign vs_sat = (vs_add[64] != vs_add[63]) ? (vs_add[64] ? S64_MIN : S64_MAX)
                                               : vs_add[63:0];
    assign ws_add = {1'b0, ws_rd} + {17'd0, chunk_w_reg};

    // readout prep
    assign lf = limit_reg[16] ? 17'h10000 : limit_reg;
    assign lim_prod = 65'(lf) * 65'(tot_w_reg);
    assign neg = vs_rd[63];
    assign s_mag = neg ? (64'd0 - vs_rd) : vs_rd;
    assign num = s_mag + {25'd0, ws_rd[39:1]};

    always_comb
    begin
        we = 1'b0;
        waddr = AW'(cell_reg);
        vs_wd = 64'd0;
        ws_wd = 40'd0;
        if (cmd.clr_step)
        begin
            we = 1'b1;
            waddr = clr_addr_reg[AW-1:0];
        end
        else if (cmd.exec && in_range)
        begin
            if (cmd_reg == mwtm_pkg::CMD_SAMPLE && sv_reg != in_miss_reg)
            begin
                we = 1'b1;
                vs_wd = vs_sat;
                ws_wd = ws_add[40] ? {40{1'b1}} : ws_add[39:0];
            end
            else if (cmd_reg == mwtm_pkg::CMD_READ)
            begin
                we = 1'b1;
            end
        end
    end

    mwtm_ram #(.WIDTH(64), .DEPTH(RD)) u_vs (
        .clk(clk), .we(we), .waddr(waddr), .wdata(vs_wd),
        .raddr(AW'(cell_reg)), .rdata(vs_rd)
    );

    mwtm_ram #(.WIDTH(40), .DEPTH(RD)) u_ws (
        .clk(clk), .we(we), .waddr(waddr), .wdata(ws_wd),
        .raddr(AW'(cell_reg)), .rdata(ws_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            tot_w_reg <= '0;
            tot_d_reg <= '0;
            chunk_w_reg <= mwtm_pkg::ONE_Q8;
            chunk_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.exec && cmd_reg == mwtm_pkg::CMD_CHUNK)
            begin
                if (reject)
                begin
                    chunk_w_reg <= '0;
                end
                else
                begin
                    chunk_w_reg <= (ignore_reg || dt == 24'd0) ? mwtm_pkg::ONE_Q8 : dt;
                    if (chunk_cnt_reg != 16'hFFFF)
                    begin
                        chunk_cnt_reg <= chunk_cnt_reg + 16'd1;
                    end
                    tot_d_reg <= ({1'b0, tot_d_reg} + 49'(dt) > 49'h0FFFF_FFFF_FFFF)
                        ? {48{1'b1}} : tot_d_reg + 48'(dt);
                    tot_w_reg <= ({1'b0, tot_w_reg} + 49'((ignore_reg || dt == 24'd0)
                        ? mwtm_pkg::ONE_Q8 : dt) > 49'h0FFFF_FFFF_FFFF)
                        ? {48{1'b1}}
                        : tot_w_reg + 48'((ignore_reg || dt == 24'd0)
                            ? mwtm_pkg::ONE_Q8 : dt);
                end
            end
            if (cmd.exec && cmd_reg == mwtm_pkg::CMD_CLEAR)
            begin
                tot_w_reg <= '0;
                tot_d_reg <= '0;
                chunk_cnt_reg <= '0;
            end
        end
    end

    // capture readout operands
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            chunk_res_reg <= (cmd_reg == mwtm_pkg::CMD_CHUNK);
            rej_reg <= reject;
            neg_reg <= neg;
            integ_res_reg <= integ_reg;
            miss_reg <= !in_range || ws_rd == 40'd0
                || ({ws_rd, 16'd0} < lim_prod[63:0]) || lim_prod[64];
            hi_p <= {32'd0, s_mag[63:32]} * {32'd0, scale_reg};
            lo_p <= {32'd0, s_mag[31:0]} * {32'd0, scale_reg} + 64'h80_0000;
        end
    end

    // operands are taken straight from the memory read in the start cycle
    mwtm_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(num), .divisor(ws_rd),
        .done(div_done), .quotient(quo)
    );

    assign isum = {24'd0, hi_p[31:0], 8'd0} + {24'd0, lo_p[63:24]};

    always_comb
    begin
        if (integ_res_reg)
        begin
            mag = (hi_p >= 64'h100_0000 || isum[63:33] != 31'd0) ? 33'h1_0000_0000
                                                                : isum[32:0];
        end
        else
        begin
            mag = (quo[63:33] != 31'd0) ? 33'h1_0000_0000 : quo[32:0];
        end
        if (neg_reg)
        begin
            res_val = (mag >= 33'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
        end
        else
        begin
            res_val = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (chunk_res_reg)
            begin
                mean_value <= '0;
                is_missing <= 1'b0;
                status <= rej_reg;
            end
            else if (miss_reg)
            begin
                mean_value <= out_miss_reg;
                is_missing <= 1'b1;
                status <= 1'b0;
            end
            else
            begin
                mean_value <= res_val;
                is_missing <= 1'b0;
                status <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.clr_last = (clr_addr_reg == (AW+1)'(RD - 1));
        stat.has_out = (cmd_reg == mwtm_pkg::CMD_CHUNK) || (cmd_reg == mwtm_pkg::CMD_READ);
        stat.need_div = (cmd_reg == mwtm_pkg::CMD_READ) && !integ_reg && in_range
            && ws_rd != 40'd0;
        stat.div_done = div_done;
    end

`ifndef SYNTHESIS
    a_sat_ws: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && cmd_reg == mwtm_pkg::CMD_SAMPLE && we) |-> (ws_wd >= ws_rd))
        else $error("weight sum wrapped");
    a_clr_tot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && cmd_reg == mwtm_pkg::CMD_CLEAR) |=> (tot_w_reg == 48'd0))
        else $error("totals not cleared");
    a_rej_w: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && cmd_reg == mwtm_pkg::CMD_CHUNK && reject) |=> (chunk_w_reg == 24'd0))
        else $error("rejected chunk kept weight");
`endif

endmodule

// File: design/masked_weighted_time_mean.sv
// Sample and clear pass the read and execute states and give no result; begin chunk and
// integrating readout then load the result; mean readout waits on the 64-bit divider.
// Throughput: one transaction at a time; next input taken once the controller is idle again.
// Reset: asynchronous, active low; after reset a sweep zeroes every address of the cell
// memories, input held stalled meanwhile; configuration writes are taken at once.
module masked_weighted_time_mean #(
    parameter int GRID_CELLS = mwtm_pkg::GRID_CELLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [11:0]        cell_req,
    input  logic signed [31:0] sample_value,
    input  logic signed [23:0] chunk_hours,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] mean_value,
    output logic               is_missing,
    output logic               status
);

    mwtm_pkg::mwtm_cmd_t  ctl;
    mwtm_pkg::mwtm_stat_t st;

    assign cfg_ready = 1'b1;

    mwtm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(ctl), .stat(st)
    );

    mwtm_dp #(.GRID_CELLS(GRID_CELLS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(ctl), .stat(st),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_cmd(cmd), .cell_req(cell_req), .sample_value(sample_value),
        .chunk_hours(chunk_hours), .mean_value(mean_value),
        .is_missing(is_missing), .status(status)
    );

endmodule

// File: sim/masked_weighted_time_mean_test.sv
`timescale 1ns / 100ps

module masked_weighted_time_mean_test;

    localparam int CELLS = mwtm_pkg::GRID_CELLS_DEF;
    localparam int HANG_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] mean;
        logic               miss;
        logic               stat;
    } cell_result_t;

    // Tracks the block's accumulators and queues the results each transaction should cause.
    class mean_scoreboard;
        logic [31:0] in_miss, out_miss;
        logic [16:0] limit_frac;
        logic        integ, ignore_dur;
        logic [31:0] scale;
        logic signed [63:0] vsum [CELLS];
        logic [39:0] wsum [CELLS];
        logic [47:0] tot_weight, tot_dur;
        logic [23:0] chunk_w;
        logic [15:0] chunk_cnt;
        cell_result_t pending[$];
        int mismatches;
        int results_seen;

        function new();
            in_miss = mwtm_pkg::MISS_RESET;
            out_miss = mwtm_pkg::MISS_RESET;
            limit_frac = 0;
            integ = 0;
            scale = 32'd65536;
            ignore_dur = 0;
            tot_weight = 0;
            tot_dur = 0;
            chunk_w = mwtm_pkg::ONE_Q8;
            chunk_cnt = 0;
            mismatches = 0;
            results_seen = 0;
            for (int i = 0; i < CELLS; i++)
            begin
                vsum[i] = 0;
                wsum[i] = 0;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                mwtm_pkg::REG_IN_MISS: in_miss = data;
                mwtm_pkg::REG_OUT_MISS: out_miss = data;
                mwtm_pkg::REG_LIMIT: limit_frac = data[16:0];
                mwtm_pkg::REG_INTEG: integ = data[0];
                mwtm_pkg::REG_SCALE: scale = data;
                mwtm_pkg::REG_IGNORE: ignore_dur = data[0];
                default: ;
            endcase
        endfunction

        function logic [47:0] add48(logic [47:0] a, logic [47:0] b);
            logic [48:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[48] ? '1 : s[47:0];
        endfunction

        function logic [31:0] saturate(logic [64:0] mag, logic neg);
            if (neg)
                return (mag >= 65'h80000000) ? 32'h80000000 : 32'd0 - mag[31:0];
            return (mag > 65'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
        endfunction

        function void note_input(logic [1:0] op, logic [11:0] cell_idx, logic [31:0] sv,
                                 logic [23:0] hours);
            cell_result_t r;
            logic [23:0] dt, w;
            logic signed [63:0] prod;
            logic signed [64:0] wide;
            logic [40:0] wnext;
            logic [39:0] ws;
            logic signed [63:0] s;
            logic [63:0] smag;
            logic [16:0] lf;
            logic [63:0] hi, lo;
            logic [64:0] mag;
            r = '0;
            case (op)
                mwtm_pkg::CMD_CHUNK:
                begin
                    dt = hours[23] ? 24'd0 : hours;
                    if (dt == 0 && tot_dur > 0 && !ignore_dur)
                    begin
                        chunk_w = 0;
                        r.stat = 1;
                    end
                    else
                    begin
                        w = (ignore_dur || dt == 0) ? mwtm_pkg::ONE_Q8 : dt;
                        chunk_w = w;
                        if (chunk_cnt != 16'hFFFF)
                            chunk_cnt++;
                        tot_dur = add48(tot_dur, {24'd0, dt});
                        tot_weight = add48(tot_weight, {24'd0, w});
                    end
                    pending.push_back(r);
                end
                mwtm_pkg::CMD_SAMPLE:
                begin
                    if (sv != in_miss)
                    begin
                        prod = $signed(sv) * $signed({1'b0, chunk_w});
                        wide = $signed({vsum[cell_idx][63], vsum[cell_idx]})
                            + $signed({prod[63], prod});
                        if (wide[64] != wide[63])
                            vsum[cell_idx] = wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                        else
                            vsum[cell_idx] = wide[63:0];
                        wnext = {1'b0, wsum[cell_idx]} + chunk_w;
                        wsum[cell_idx] = wnext[40] ? '1 : wnext[39:0];
                    end
                end
                mwtm_pkg::CMD_READ:
                begin
                    r.mean = out_miss;
                    r.miss = 1;
                    ws = wsum[cell_idx];
                    s = vsum[cell_idx];
                    vsum[cell_idx] = 0;
                    wsum[cell_idx] = 0;
                    lf = (limit_frac > 17'd65536) ? 17'd65536 : limit_frac;
                    if (!(ws == 0 || ({ws, 16'd0} < ({17'd0, lf} * {17'd0, tot_weight}))))
                    begin
                        smag = s[63] ? 64'd0 - s : s;
                        if (integ)
                        begin
                            hi = smag[63:32] * {32'd0, scale};
                            lo = smag[31:0] * {32'd0, scale} + (64'd1 << 23);
                            if (hi >= (64'd1 << 24))
                                mag = 65'd1 << 32;
                            else
                                mag = {1'b0, hi << 8} + (lo >> 24);
                        end
                        else
                            mag = ({1'b0, smag} + (ws >> 1)) / ws;
                        r.mean = saturate(mag, s[63]);
                        r.miss = 0;
                    end
                    pending.push_back(r);
                end
                default:
                begin
                    tot_weight = 0;
                    tot_dur = 0;
                    chunk_cnt = 0;
                end
            endcase
        endfunction

        function void check_result(cell_result_t got);
            cell_result_t want;
            results_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result mean=%h miss=%b status=%b",
                             got.mean, got.miss, got.stat);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: mean %h/%h miss %b/%b status %b/%b (expected/actual)",
                             want.mean, got.mean, want.miss, got.miss, want.stat, got.stat);
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic cfg_valid, cfg_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    logic in_valid, in_stall;
    logic [1:0] cmd;
    logic [11:0] cell_req;
    logic signed [31:0] sample_value;
    logic signed [23:0] chunk_hours;
    logic out_valid, out_stall;
    logic signed [31:0] mean_value;
    logic is_missing, status;

    masked_weighted_time_mean uut (.*);

    mean_scoreboard sb;
    int send_idle_pct, recv_stall_pct;
    int items_sent;
    int idle_cycles;
    bit hung;
    logic [31:0] in_miss_now;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Output side: random stall, check on every accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                sb.check_result({mean_value, is_missing, status});
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on cycles with no accepted transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT && !hung)
        begin
            hung = 1;
            $display("timeout waiting for a transaction");
            $display("status: fail");
            $finish;
        end
    end

    // valid stays up into the next call so back-to-back transactions need no gap
    task automatic send_item(logic [1:0] op, logic [11:0] cell_idx, logic [31:0] sv,
                             logic [23:0] hours);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        cell_req <= cell_idx;
        sample_value <= sv;
        chunk_hours <= hours;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(op, cell_idx, sv, hours);
        items_sent++;
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        if (idx == mwtm_pkg::REG_IN_MISS)
            in_miss_now = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        // samples and clears give no result but may still be in flight
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return in_miss_now;
            1: return 32'h7FFFFFFF;
            2: return 32'h80000000;
            3: return $urandom_range(2047) - 1024;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] rand_hours();
        case ($urandom_range(6))
            0: return 24'd0;
            1: return 24'($urandom | 32'h800000);
            2: return 24'h7FFFFF;
            default: return 24'($urandom_range(4096, 1));
        endcase
    endfunction

    // Mostly chunk/sample/readout sequences on a few cells so reads see real sums.
    task automatic random_phase(int n);
        int k;
        int reps;
        logic do_clear;
        logic [11:0] base;
        k = 0;
        while (k < n)
        begin
            base = $urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(7));
            if ($urandom_range(9) == 0)
            begin
                send_item(2'($urandom), 12'($urandom), $urandom, 24'($urandom));
                k++;
            end
            else
            begin
                reps = $urandom_range(6, 1);
                do_clear = ($urandom_range(4) == 0);
                send_item(mwtm_pkg::CMD_CHUNK, 12'($urandom), $urandom, rand_hours());
                repeat (reps)
                    send_item(mwtm_pkg::CMD_SAMPLE, base + 12'($urandom_range(2)),
                              rand_value(), 24'($urandom));
                if (do_clear)
                    send_item(mwtm_pkg::CMD_CLEAR, 12'($urandom), $urandom, 24'($urandom));
                send_item(mwtm_pkg::CMD_READ, base + 12'($urandom_range(2)), $urandom,
                          24'($urandom));
                k += reps + 2 + int'(do_clear);
            end
        end
    endtask

    initial
    begin
        sb = new();
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        in_miss_now = mwtm_pkg::MISS_RESET;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = '0;
        cell_req = '0;
        sample_value = '0;
        chunk_hours = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes and special cases
        send_item(mwtm_pkg::CMD_READ, 12'd5, 32'd0, 24'd0);           // empty cell
        send_item(mwtm_pkg::CMD_CHUNK, 12'd0, 32'd0, 24'd0);          // zero first: weight one
        send_item(mwtm_pkg::CMD_SAMPLE, 12'd0, 32'h7FFFFFFF, 24'd0);
        send_item(mwtm_pkg::CMD_SAMPLE, 12'd0, mwtm_pkg::MISS_RESET, 24'd0);    // masked
        send_item(mwtm_pkg::CMD_SAMPLE, 12'hFFF, 32'h80000000, 24'hFFFFFF);
        send_item(mwtm_pkg::CMD_READ, 12'd0, 32'd0, 24'd0);
        send_item(mwtm_pkg::CMD_CHUNK, 12'd0, 32'd0, 24'h7FFFFF);
        send_item(mwtm_pkg::CMD_SAMPLE, 12'd1, 32'hFFFFFFFF, 24'd0);
        send_item(mwtm_pkg::CMD_CHUNK, 12'd0, 32'd0, 24'h800000);     // negative clamps, rejected
        send_item(mwtm_pkg::CMD_SAMPLE, 12'd1, 32'd1000, 24'd0);
        send_item(mwtm_pkg::CMD_READ, 12'd1, 32'd0, 24'd0);
        send_item(mwtm_pkg::CMD_READ, 12'hFFF, 32'd0, 24'd0);
        send_item(mwtm_pkg::CMD_CLEAR, 12'd0, 32'd0, 24'd0);
        send_item(mwtm_pkg::CMD_CHUNK, 12'd0, 32'd0, 24'd1);
        send_item(mwtm_pkg::CMD_SAMPLE, 12'd2, 32'h00000180, 24'd0);
        send_item(mwtm_pkg::CMD_READ, 12'd2, 32'd0, 24'd0);
        drain();

        write_cfg(mwtm_pkg::REG_IN_MISS, 32'd0);
        write_cfg(mwtm_pkg::REG_OUT_MISS, 32'h7FFFFFFF);
        write_cfg(mwtm_pkg::REG_LIMIT, 32'h1FFFF);                    // above one acts as one
        write_cfg(mwtm_pkg::REG_INTEG, 32'd1);
        write_cfg(mwtm_pkg::REG_SCALE, 32'hFFFFFFFF);
        write_cfg(mwtm_pkg::REG_IGNORE, 32'd1);
        random_phase(200);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                3: begin send_idle_pct = 16; recv_stall_pct = 16; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            write_cfg(mwtm_pkg::REG_IN_MISS, ph == 4 ? 32'h80000000 : $urandom);
            write_cfg(mwtm_pkg::REG_OUT_MISS, ph == 4 ? 32'h80000000 : $urandom);
            write_cfg(mwtm_pkg::REG_LIMIT, ph == 0 ? 32'd0 : $urandom_range(65536));
            write_cfg(mwtm_pkg::REG_INTEG, 32'(ph % 2));
            write_cfg(mwtm_pkg::REG_SCALE, ph == 0 ? 32'd0 : $urandom);
            write_cfg(mwtm_pkg::REG_IGNORE, 32'(ph == 3));
            random_phase(200);
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        $display("sent %0d transactions across 7 configurations, checked %0d results",
                 items_sent, sb.results_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
design/mwtm_pkg.sv
design/mwtm_ram.sv
design/mwtm_div.sv
design/mwtm_ctrl.sv
design/mwtm_dp.sv
design/masked_weighted_time_mean.sv
sim/masked_weighted_time_mean_test.sv
